// ===== sv/ewvp_pkg.sv =====
// Shared types, constants and state codes for the EWMA variance predictor.
package ewvp_pkg;

    // Fixed field widths of the item formats.
    localparam int PRICE_FIELD_BITS = 32;
    localparam int Q_BITS           = 32;
    localparam int DECAY_BITS       = 16;

    // Defaults for the top-level parameters.
    localparam int PRICE_WIDTH_DEF         = 32;
    localparam int DECAY_FRACTION_BITS_DEF = 16;

    // Decay factor after reset (about 0.94 in Q0.16).
    localparam logic [DECAY_BITS-1:0] DECAY_RESET = 16'd61604;

    // Largest Q0.32 value, used when the squared return clips.
    localparam logic [Q_BITS-1:0] Q_MAX = '1;

    // Sample position codes.
    localparam logic [1:0] POS_EMPTY  = 2'd0;
    localparam logic [1:0] POS_ONE    = 2'd1;
    localparam logic [1:0] POS_SEEDED = 2'd2;

    // One input item.
    typedef struct packed {
        logic [PRICE_FIELD_BITS-1:0] price;
        logic                        last_in_series;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [Q_BITS-1:0] variance;
        logic              saturated;
        logic              zero_price_error;
    } t_out_item;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_SQR,
        ST_MAC,
        ST_DONE
    } t_state;

endpackage

// ===== sv/ewvp_div.sv =====
// Bit-serial restoring divider that forms floor(num * 2^32 / den) for num < den.
module ewvp_div #(
    parameter int PRICE_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [PRICE_WIDTH-1:0]          i_num,
    input  logic [PRICE_WIDTH-1:0]          i_den,
    output logic                            o_done,
    output logic [ewvp_pkg::Q_BITS-1:0]     o_quot
);
    import ewvp_pkg::*;

    localparam int CW = $clog2(Q_BITS);

    logic                   r_busy;
    logic                   r_done;
    logic [CW-1:0]          r_cnt;
    logic [PRICE_WIDTH-1:0] r_rem;
    logic [Q_BITS-1:0]      r_quot;

    logic [PRICE_WIDTH:0]   shifted;
    logic [PRICE_WIDTH:0]   diff;
    logic                   take;
    logic                   last_step;

    // One quotient bit per cycle: shift the remainder and try the subtract.
    assign shifted   = {r_rem, 1'b0};
    assign diff      = shifted - {1'b0, i_den};
    assign take      = shifted >= {1'b0, i_den};
    assign last_step = r_cnt == CW'(Q_BITS - 1);

    // Control: busy flag, step count and a done pulse after the last bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last_step;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last_step) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath: remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= take ? diff[PRICE_WIDTH-1:0] : shifted[PRICE_WIDTH-1:0];
            r_quot <= {r_quot[Q_BITS-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== sv/ewvp_sqr.sv =====
// Bit-serial squarer that returns the upper half of a 32 by 32 bit product.
module ewvp_sqr (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ewvp_pkg::Q_BITS-1:0] i_op,
    output logic                        o_done,
    output logic [ewvp_pkg::Q_BITS-1:0] o_square
);
    import ewvp_pkg::*;

    localparam int CW = $clog2(Q_BITS);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [Q_BITS-1:0] r_mult;
    logic [Q_BITS-1:0] r_hi;

    logic [Q_BITS:0]   sum;
    logic              last_step;

    // Add the operand when the current multiplier bit is set, then shift right.
    // The bits shifted out never feed back, so only the high half is kept.
    assign sum       = {1'b0, r_hi} + (r_mult[0] ? {1'b0, i_op} : '0);
    assign last_step = r_cnt == CW'(Q_BITS - 1);

    // Control: busy flag, step count and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last_step;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last_step) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath: multiplier shift register and high accumulator.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mult <= i_op;
            r_hi   <= '0;
        end else if (r_busy) begin
            r_mult <= {1'b0, r_mult[Q_BITS-1:1]};
            r_hi   <= sum[Q_BITS:1];
        end
    end

    assign o_done   = r_done;
    assign o_square = r_hi;

endmodule

// ===== sv/ewvp_mac.sv =====
// Bit-serial weighted mean: floor((lam * var + (2^F - lam) * u) / 2^F).
module ewvp_mac #(
    parameter int DECAY_FRACTION_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [DECAY_FRACTION_BITS:0]   i_lambda,
    input  logic [ewvp_pkg::Q_BITS-1:0]    i_var,
    input  logic [ewvp_pkg::Q_BITS-1:0]    i_u,
    output logic                           o_done,
    output logic [ewvp_pkg::Q_BITS-1:0]    o_result
);
    import ewvp_pkg::*;

    localparam int F  = DECAY_FRACTION_BITS;
    localparam int CW = $clog2(F + 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [F:0]        r_lam;
    logic [F:0]        r_wgt;
    logic [Q_BITS:0]   r_hi;
    logic [Q_BITS-1:0] r_result;

    logic [F:0]        one;
    logic [Q_BITS+1:0] sum;
    logic              last_step;

    assign one = (F + 1)'(1) << F;

    // Both weights are walked LSB first; the top weight bit is added
    // without a shift so that the sum ends up divided by 2^F.
    assign sum = {1'b0, r_hi}
               + (r_lam[0] ? {2'b00, i_var} : '0)
               + (r_wgt[0] ? {2'b00, i_u} : '0);
    assign last_step = r_cnt == CW'(F);

    // Control: busy flag, step count and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last_step;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last_step) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath: weight shift registers, accumulator and result.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_lam <= i_lambda;
            r_wgt <= one - i_lambda;
            r_hi  <= '0;
        end else if (r_busy) begin
            r_lam <= {1'b0, r_lam[F:1]};
            r_wgt <= {1'b0, r_wgt[F:1]};
            if (last_step) begin
                r_result <= sum[Q_BITS-1:0];
            end else begin
                r_hi <= sum[Q_BITS+1:1];
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== sv/ewma_variance_predictor_unit.sv =====
// EWMA variance predictor: sequencer, series state and output register.
//
// Usage: one price sample is transferred on the input channel when
// i_in_valid is high and o_in_stall is low; one result is transferred on the
// output channel when o_out_valid is high and i_out_stall is low. Each input
// item yields exactly one result. The decay factor is written through
// i_cfg_we / i_cfg_data; the user must write it only while the block is idle, as the block does not enforce this.
// Processing: the first sample of a series and a sample after a zero price
// go straight to the result. A clipped return skips the divider and
// squarer. A full update runs a bit-serial divide, a bit-serial square and
// a serial multiply-accumulate, in that order. One item is processed at a
// time; the next one can be taken in the cycle after the previous result is loaded.
// Reset clears the series state and restores the decay factor to about 0.94.
// A stalled result is held in the output register; a finished item waits in
// ST_DONE until the register frees up, while no new item is taken.
module ewma_variance_predictor_unit #(
    parameter int PRICE_WIDTH         = ewvp_pkg::PRICE_WIDTH_DEF,
    parameter int DECAY_FRACTION_BITS = ewvp_pkg::DECAY_FRACTION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  ewvp_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output ewvp_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [ewvp_pkg::DECAY_BITS-1:0] i_cfg_data
);
    import ewvp_pkg::*;

    localparam int PW = PRICE_WIDTH;
    localparam int F  = DECAY_FRACTION_BITS;
    localparam int EW = (PW > PRICE_FIELD_BITS) ? PW : PRICE_FIELD_BITS;
    localparam int LW = (F + 1 > DECAY_BITS) ? F + 1 : DECAY_BITS;

    t_state r_state;
    t_state n_state;

    logic [DECAY_BITS-1:0] r_decay;
    logic [PW-1:0]         r_prev;
    logic [PW-1:0]         r_price;
    logic                  r_last;
    logic [1:0]            r_pos;
    logic [Q_BITS-1:0]     r_runvar;
    logic [Q_BITS-1:0]     r_u;
    logic                  r_sat;
    logic                  r_err;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic [EW-1:0]         price_ext;
    logic [PW-1:0]         diff;
    logic                  clip;
    logic                  first;
    logic                  zero_prev;
    logic [LW-1:0]         lam_ext;
    logic [LW-1:0]         one_ext;
    logic [LW-1:0]         lam_lim;

    logic                  in_take;
    logic                  div_start;
    logic                  sqr_start;
    logic                  mac_start;
    logic                  out_load;
    logic                  out_free;

    logic                  div_done;
    logic [Q_BITS-1:0]     div_quot;
    logic                  sqr_done;
    logic [Q_BITS-1:0]     sqr_square;
    logic                  mac_done;
    logic [Q_BITS-1:0]     mac_result;

    // Input price limited to the configured width.
    assign price_ext = EW'(i_in_data.price);

    // Return magnitude and the special cases of the current item.
    assign diff      = (r_price >= r_prev) ? r_price - r_prev : r_prev - r_price;
    assign clip      = diff >= r_prev;
    assign first     = r_pos == POS_EMPTY;
    assign zero_prev = r_prev == '0;

    // Decay factor limited to one.
    assign lam_ext = LW'(r_decay);
    assign one_ext = LW'(1) << F;
    assign lam_lim = (lam_ext > one_ext) ? one_ext : lam_ext;

    assign out_free = !r_out_valid || !i_out_stall;

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (first || zero_prev) begin
                    n_state = ST_DONE;
                end else if (!clip) begin
                    n_state = ST_DIV;
                end else if (r_pos == POS_ONE) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_MAC;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_SQR;
                end
            end
            ST_SQR: begin
                if (sqr_done) begin
                    n_state = (r_pos == POS_ONE) ? ST_DONE : ST_MAC;
                end
            end
            ST_MAC: begin
                if (mac_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: unit starts, input stall and result load.
    always_comb begin
        o_in_stall = 1'b1;
        div_start  = 1'b0;
        sqr_start  = 1'b0;
        mac_start  = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            ST_IDLE: o_in_stall = 1'b0;
            ST_EVAL: begin
                div_start = !first && !zero_prev && !clip;
                mac_start = !first && !zero_prev && clip && (r_pos != POS_ONE);
            end
            ST_SQR:  mac_start = sqr_done && (r_pos != POS_ONE);
            ST_DIV:  sqr_start = div_done;
            ST_DONE: out_load  = out_free;
            default: o_in_stall = 1'b1;
        endcase
    end

    assign in_take = i_in_valid && !o_in_stall;

    // State register and output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Decay factor register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay <= DECAY_RESET;
        end else if (i_cfg_we) begin
            r_decay <= i_cfg_data;
        end
    end

    // Series state: previous price, position and running variance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_pos    <= POS_EMPTY;
            r_runvar <= '0;
        end else begin
            if (r_state == ST_EVAL) begin
                if (first) begin
                    r_pos    <= POS_ONE;
                    r_runvar <= '0;
                end else if (!zero_prev && clip && r_pos == POS_ONE) begin
                    r_runvar <= Q_MAX;
                    r_pos    <= POS_SEEDED;
                end
            end
            if (r_state == ST_SQR && sqr_done && r_pos == POS_ONE) begin
                r_runvar <= sqr_square;
                r_pos    <= POS_SEEDED;
            end
            if (r_state == ST_MAC && mac_done) begin
                r_runvar <= mac_result;
                r_pos    <= POS_SEEDED;
            end
            if (out_load) begin
                if (r_last) begin
                    r_prev   <= '0;
                    r_pos    <= POS_EMPTY;
                    r_runvar <= '0;
                end else begin
                    r_prev <= r_price;
                end
            end
        end
    end

    // Item payload, squared return and result flags.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_price <= price_ext[PW-1:0];
            r_last  <= i_in_data.last_in_series;
        end
        if (r_state == ST_EVAL) begin
            r_sat <= !first && !zero_prev && clip;
            r_err <= !first && zero_prev;
            r_u   <= Q_MAX;
        end
        if (sqr_start) begin
            r_u <= r_u;
        end
        if (r_state == ST_SQR && sqr_done) begin
            r_u <= sqr_square;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.variance         <= r_runvar;
            r_out.saturated        <= r_sat;
            r_out.zero_price_error <= r_err;
        end
    end

    ewvp_div #(
        .PRICE_WIDTH(PW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (diff),
        .i_den   (r_prev),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    ewvp_sqr u_sqr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (sqr_start),
        .i_op     (div_quot),
        .o_done   (sqr_done),
        .o_square (sqr_square)
    );

    ewvp_mac #(
        .DECAY_FRACTION_BITS(F)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mac_start),
        .i_lambda (lam_lim[F:0]),
        .i_var    (r_runvar),
        .i_u      (r_u),
        .o_done   (mac_done),
        .o_result (mac_result)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== test/tb_ewma_variance_predictor_unit.sv =====
// Self-checking testbench for the EWMA variance predictor unit.
`timescale 1ns / 1ps

module tb_ewma_variance_predictor_unit;
    import ewvp_pkg::*;

    localparam int          CYCLE_LIMIT    = 1_500_000;
    localparam int          SETTLE_CYCLES  = 4;
    localparam int          TAIL_CYCLES    = 120;
    localparam int          HOLD_OFF_LEN   = 300;
    localparam int          MAX_REPORTS    = 10;
    localparam int          FRAC_BITS      = DECAY_FRACTION_BITS_DEF;
    localparam logic [63:0] UNITY          = 64'd1 << FRAC_BITS;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_we    = 1'b0;
    logic [DECAY_BITS-1:0] i_cfg_data  = '0;

    // Predictor state: decay register and the current price series.
    logic [DECAY_BITS-1:0] decay_q16   = DECAY_RESET;
    logic [31:0]           prev_price  = '0;
    logic [1:0]            series_pos  = POS_EMPTY;
    logic [31:0]           var_q32     = '0;

    t_out_item   expected_variances[$];
    int          in_idle_pct      = 0;
    int          out_stall_pct    = 0;
    int          hold_off_left    = 0;
    int unsigned cycle_count      = 0;
    int unsigned items_sent       = 0;
    int unsigned results_checked  = 0;
    int unsigned decay_writes     = 0;
    int unsigned error_count      = 0;

    ewma_variance_predictor_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Works out the forecast for one price sample and advances the series state.
    function automatic t_out_item forecast_variance(input t_in_item sample);
        t_out_item   res;
        logic [31:0] diff;
        logic [63:0] ratio;
        logic [63:0] sq_return;
        logic [63:0] lam;
        logic [63:0] mix;
        res = '0;
        if (series_pos == POS_EMPTY) begin
            // First sample of a series only records the price.
            series_pos = POS_ONE;
            var_q32    = '0;
        end else if (prev_price == '0) begin
            // No return can be formed; report and hold the variance.
            res.zero_price_error = 1'b1;
            res.variance         = var_q32;
        end else begin
            diff = (sample.price >= prev_price) ? sample.price - prev_price
                                                : prev_price - sample.price;
            if (diff >= prev_price) begin
                sq_return     = {32'd0, Q_MAX};
                res.saturated = 1'b1;
            end else begin
                ratio     = {diff, 32'd0} / {32'd0, prev_price};
                sq_return = (ratio * ratio) >> 32;
            end
            if (series_pos == POS_ONE) begin
                var_q32 = sq_return[31:0];
            end else begin
                lam     = ({48'd0, decay_q16} > UNITY) ? UNITY : {48'd0, decay_q16};
                mix     = lam * {32'd0, var_q32} + (UNITY - lam) * sq_return;
                var_q32 = mix[FRAC_BITS +: 32];
            end
            series_pos   = POS_SEEDED;
            res.variance = var_q32;
        end
        prev_price = sample.price;
        if (sample.last_in_series) begin
            prev_price = '0;
            series_pos = POS_EMPTY;
            var_q32    = '0;
        end
        return res;
    endfunction

    // Offers one price sample and returns at the edge where it transfers.
    task automatic send_price(input logic [31:0] price, input logic last_mark);
        t_in_item sample;
        sample.price          = price;
        sample.last_in_series = last_mark;
        while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= sample;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_variances.push_back(forecast_variance(sample));
        items_sent++;
    endtask

    // Stops offering samples and waits until every result has come back.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_variances.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the decay factor once the block has gone idle.
    task automatic write_decay(input logic [DECAY_BITS-1:0] lambda_q16);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= lambda_q16;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        decay_q16  = lambda_q16;
        decay_writes++;
    endtask

    // Sends random-walk price series with some noise and broken series mixed in.
    task automatic send_random_series(input int n_items);
        int          sent;
        int          len;
        int          k;
        int unsigned pick;
        logic [31:0] px;
        logic [31:0] delta;
        logic [32:0] up;
        logic        end_mark;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(2, 24);
            px  = $urandom >> $urandom_range(0, 28);
            if (px == '0) px = 32'd1;
            for (k = 0; k < len && sent < n_items; k++) begin
                pick = $urandom_range(99);
                if (pick < 5) begin
                    px = '0;
                end else if (pick < 10) begin
                    px = $urandom;
                end else if (pick < 14) begin
                    px = $urandom_range(1, 4);
                end else begin
                    // Small relative move up or down.
                    delta = px >> $urandom_range(1, 16);
                    delta = (delta == '0) ? $urandom_range(0, 2) : $urandom_range(0, delta);
                    up    = {1'b0, px} + {1'b0, delta};
                    if ($urandom_range(1) == 1 && !up[32]) px = up[31:0];
                    else if (delta <= px)                 px = px - delta;
                    else                                  px = up[31:0];
                end
                // Most series end with the marker; a few are cut short or run on.
                end_mark = (k == len - 1) ? ($urandom_range(19) != 0)
                                          : ($urandom_range(49) == 0);
                send_price(px, end_mark);
                sent++;
            end
        end
    endtask

    // Hand-picked series: seeding, updates, clipping, zero prices and markers.
    task automatic test_directed_series();
        send_price(32'd1000, 1'b0);
        send_price(32'd1010, 1'b0);
        send_price(32'd990, 1'b0);
        send_price(32'd2000, 1'b0);
        send_price(32'd0, 1'b0);
        send_price(32'd500, 1'b0);
        send_price(32'd600, 1'b0);
        send_price(32'd700, 1'b1);
        send_price(32'd0, 1'b0);
        send_price(32'd0, 1'b0);
        send_price(32'd5, 1'b0);
        send_price(32'd7, 1'b0);
        send_price(32'hFFFF_FFFF, 1'b1);
        send_price(32'hFFFF_FFFF, 1'b0);
        send_price(32'hFFFF_FFFE, 1'b0);
        send_price(32'h7FFF_FFFF, 1'b0);
        send_price(32'h8000_0000, 1'b0);
        send_price(32'h8000_0000, 1'b0);
        send_price(32'd1, 1'b1);
        send_price(32'd1, 1'b0);
        send_price(32'd1, 1'b1);
        send_price(32'd3, 1'b1);
    endtask

    // Short series under the extreme and midpoint decay factors.
    task automatic test_decay_extremes();
        write_decay(16'd0);
        send_random_series(10);
        write_decay(16'hFFFF);
        send_random_series(10);
        write_decay(16'h8000);
        send_random_series(10);
        write_decay(16'd1);
        send_random_series(10);
    endtask

    // Random series over the idle and stall phases, a new decay each phase.
    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < 4; phase++) begin
            write_decay(DECAY_BITS'($urandom_range(0, 16'hFFFF)));
            case (phase)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 83; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 83; end
                default: begin in_idle_pct = 38; out_stall_pct = 38; end
            endcase
            send_random_series(200);
        end
    endtask

    // The receiver holds off for a long stretch while samples keep coming.
    task automatic test_backpressure();
        int n;
        write_decay(DECAY_RESET);
        in_idle_pct   = 0;
        out_stall_pct = 0;
        @(negedge i_clk);
        hold_off_left = HOLD_OFF_LEN;
        @(posedge i_clk);
        for (n = 0; n < 12; n++) begin
            send_price(32'd100_000 + n * 37, n == 11);
        end
    endtask

    // Receiver: checks each result transfer and drives the stall.
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_checked++;
                if (expected_variances.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("Unexpected result transfer: var=%h sat=%b err=%b",
                                 o_out_data.variance, o_out_data.saturated,
                                 o_out_data.zero_price_error);
                end else begin
                    want = expected_variances.pop_front();
                    if (o_out_data.variance !== want.variance
                            || o_out_data.saturated !== want.saturated
                            || o_out_data.zero_price_error !== want.zero_price_error) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS) begin
                            $display("Mismatch on result %0d: expected var=%h sat=%b err=%b",
                                     results_checked, want.variance, want.saturated,
                                     want.zero_price_error);
                            $display("    got var=%h sat=%b err=%b", o_out_data.variance,
                                     o_out_data.saturated, o_out_data.zero_price_error);
                        end
                    end
                end
            end
            // A requested hold-off overrides the random stall.
            if (hold_off_left > 0) begin
                i_out_stall   <= 1'b1;
                hold_off_left  = hold_off_left - 1;
            end else begin
                i_out_stall <= (out_stall_pct != 0 && $urandom_range(99) < out_stall_pct);
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, expected_variances.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_series();
        test_decay_extremes();
        test_random_traffic();
        test_backpressure();
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d price samples and checked %0d forecasts under %0d decay writes.",
                 items_sent, results_checked, decay_writes);
        $display("Phases: directed series, decay extremes, idle/stall mixes, long hold-off.");
        if (error_count == 0 && expected_variances.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d errors, %0d results missing", error_count,
                     expected_variances.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
